// ----- hdl/tccs_pkg.sv -----
// Shared constants, codes and item/result types for the text console.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STOP = 4;

    localparam int KIND_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int CELL_W     = ATTR_W + CHAR_W;
    localparam int READ_ROW_W = 5;
    localparam int READ_COL_W = 7;
    localparam int CUR_ROW_W  = 5;
    localparam int CUR_COL_W  = 7;
    localparam int CUR_POS_W  = 11;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0A;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CHAR_W-1:0]     char_code;
        logic [READ_ROW_W-1:0] read_row;
        logic [READ_COL_W-1:0] read_col;
    } t_item;

    typedef struct packed {
        logic                 valid;
        logic [CELL_W-1:0]    cell_value;
        logic [CUR_ROW_W-1:0] cursor_row;
        logic [CUR_COL_W-1:0] cursor_col;
        logic [CUR_POS_W-1:0] cursor_position;
    } t_result;

endpackage

// ----- hdl/text_console_cursor_scroll.sv -----
// Each item goes from idle through an execute state to a done state holding the result; a read
// adds a read state, a tab writes up to TAB_STOP blank cells, a scroll blanks the row that
// leaves the top, a clear blanks every cell. One item at a time: the next item is taken once the
// result moves into the output register; the single cell-memory write port sets the sweeps.
// Reset: cursor home, attribute 0x0A, then a clearing pass over all ROWS*COLUMNS cells (2000 by
// default) with stall held high; configuration writes are taken throughout.
`timescale 1ns / 1ps

module text_console_cursor_scroll
    import tccs_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [ATTR_W-1:0]     i_cfg_wr_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [CHAR_W-1:0]     i_char_code,
    input  logic [READ_ROW_W-1:0] i_read_row,
    input  logic [READ_COL_W-1:0] i_read_col,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CELL_W-1:0]     o_cell_value,
    output logic [CUR_ROW_W-1:0]  o_cursor_row,
    output logic [CUR_COL_W-1:0]  o_cursor_col,
    output logic [CUR_POS_W-1:0]  o_cursor_position
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);

    t_item             item;
    t_result           res;
    logic              res_ready;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic              r_out_valid;
    t_result           r_out;

    assign item.kind      = i_kind;
    assign item.char_code = i_char_code;
    assign item.read_row  = i_read_row;
    assign item.read_col  = i_read_col;

    tccs_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_item        (item),
        .o_res         (res),
        .i_res_ready   (res_ready),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    tccs_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register: free when empty or being taken this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res.valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_cell_value      = r_out.cell_value;
    assign o_cursor_row      = r_out.cursor_row;
    assign o_cursor_col      = r_out.cursor_col;
    assign o_cursor_position = r_out.cursor_position;

endmodule

// ----- hdl/tccs_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`timescale 1ns / 1ps

module tccs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/tccs_ctrl.sv -----
// Console sequencer: cursor, row rotation, cell writes, scroll and clear sweeps.
`timescale 1ns / 1ps

module tccs_ctrl
    import tccs_pkg::*;
#(
    parameter int COLUMNS  = DEF_COLUMNS,
    parameter int ROWS     = DEF_ROWS,
    parameter int TAB_STOP = DEF_TAB_STOP,
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [ATTR_W-1:0] i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_item             i_item,
    output t_result           o_res,
    input  logic              i_res_ready,
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output logic [CELL_W-1:0] o_mem_wdata,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  logic [CELL_W-1:0] i_mem_rdata
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int PH_W  = $clog2(TAB_STOP);

    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [PH_W-1:0]   LAST_PH     = PH_W'(TAB_STOP - 1);
    localparam logic [ROW_W:0]    ROWS_X      = (ROW_W + 1)'(ROWS);
    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAB,
        S_READ,
        S_SCROLL,
        S_CLEAR,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_item              r_item, n_item;
    logic [ATTR_W-1:0]  r_attr;
    logic [ATTR_W-1:0]  r_sweep_attr, n_sweep_attr;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic [PH_W-1:0]    r_phase, n_phase;
    logic [ROW_W-1:0]   r_top, n_top;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic [CELL_W-1:0]  r_value, n_value;
    logic               r_boot, n_boot;

    // address path: logical row -> physical row (rotated by r_top) -> cell index
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W:0]    a_sum;
    logic [ROW_W-1:0]  a_phys;
    logic [ADDR_W-1:0] a_addr;

    logic              read_ok;
    logic              advance;
    logic              new_line;

    assign read_ok = (32'(r_item.read_row) < ROWS) && (32'(r_item.read_col) < COLUMNS);

    always_comb begin
        a_row = r_row;
        a_col = r_col;
        if (r_state == S_SCROLL) begin
            a_row = '0;
            a_col = r_sweep[COL_W-1:0];
        end else if (r_state == S_EXEC && r_item.kind == KIND_READ) begin
            a_row = ROW_W'(r_item.read_row);
            a_col = COL_W'(r_item.read_col);
        end else if (r_state == S_EXEC && r_item.char_code == CHAR_BS) begin
            a_col = r_col - COL_W'(1);
        end
        a_sum  = {1'b0, a_row} + {1'b0, r_top};
        a_phys = (a_sum >= ROWS_X) ? ROW_W'(a_sum - ROWS_X) : ROW_W'(a_sum);
        a_addr = ADDR_W'(a_phys) * COLS_A + ADDR_W'(a_col);
    end

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_sweep_attr = r_sweep_attr;
        n_row        = r_row;
        n_col        = r_col;
        n_phase      = r_phase;
        n_top        = r_top;
        n_sweep      = r_sweep;
        n_value      = r_value;
        n_boot       = r_boot;
        o_mem_we     = 1'b0;
        o_mem_waddr  = a_addr;
        o_mem_wdata  = {r_attr, CHAR_SPACE};
        advance      = 1'b0;
        new_line     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_value = '0;
                n_state = S_DONE;
                unique case (r_item.kind)
                    KIND_PUT: begin
                        unique case (r_item.char_code)
                            CHAR_LF: new_line = 1'b1;
                            CHAR_CR: begin
                                n_col   = '0;
                                n_phase = '0;
                            end
                            CHAR_BS: begin
                                if (r_col != '0) begin
                                    o_mem_we = 1'b1;
                                    n_col    = r_col - COL_W'(1);
                                    n_phase  = (r_phase == '0) ? LAST_PH : r_phase - PH_W'(1);
                                end
                            end
                            CHAR_TAB: n_state = S_TAB;
                            default: begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = {r_attr, r_item.char_code};
                                advance     = 1'b1;
                            end
                        endcase
                    end
                    KIND_READ: begin
                        if (read_ok) begin
                            n_state = S_READ;
                        end
                    end
                    KIND_CLEAR: begin
                        n_row        = '0;
                        n_col        = '0;
                        n_phase      = '0;
                        n_top        = '0;
                        n_sweep      = '0;
                        n_sweep_attr = r_attr;
                        n_state      = S_CLEAR;
                    end
                    default: ;
                endcase
            end
            S_TAB: begin
                o_mem_we = 1'b1;
                advance  = 1'b1;
                if (r_col == LAST_COL || r_phase == LAST_PH) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                n_value = i_mem_rdata;
                n_state = S_DONE;
            end
            S_SCROLL: begin
                // blank the physical row that leaves the top and becomes the bottom
                o_mem_we = 1'b1;
                n_sweep  = r_sweep + ADDR_W'(1);
                if (r_sweep == SCROLL_LAST) begin
                    n_top   = (r_top == LAST_ROW) ? '0 : r_top + ROW_W'(1);
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_sweep;
                o_mem_wdata = {r_sweep_attr, CHAR_SPACE};
                n_sweep     = r_sweep + ADDR_W'(1);
                if (r_sweep == LAST_CELL) begin
                    n_state = r_boot ? S_IDLE : S_DONE;
                    n_boot  = 1'b0;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (advance) begin
            if (r_col == LAST_COL) begin
                new_line = 1'b1;
            end else begin
                n_col   = r_col + COL_W'(1);
                n_phase = (r_phase == LAST_PH) ? '0 : r_phase + PH_W'(1);
            end
        end

        if (new_line) begin
            n_col   = '0;
            n_phase = '0;
            if (r_row == LAST_ROW) begin
                n_sweep = '0;
                n_state = S_SCROLL;
            end else begin
                n_row = r_row + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_boot       <= 1'b1;
            r_sweep      <= '0;
            r_sweep_attr <= RESET_ATTR;
            r_attr       <= RESET_ATTR;
            r_row        <= '0;
            r_col        <= '0;
            r_phase      <= '0;
            r_top        <= '0;
        end else begin
            r_state      <= n_state;
            r_boot       <= n_boot;
            r_sweep      <= n_sweep;
            r_sweep_attr <= n_sweep_attr;
            r_row        <= n_row;
            r_col        <= n_col;
            r_phase      <= n_phase;
            r_top        <= n_top;
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
        end
        r_item  <= n_item;
        r_value <= n_value;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_mem_raddr = a_addr;

    always_comb begin
        o_res.valid           = (r_state == S_DONE);
        o_res.cell_value      = r_value;
        o_res.cursor_row      = CUR_ROW_W'(r_row);
        o_res.cursor_col      = CUR_COL_W'(r_col);
        o_res.cursor_position = CUR_POS_W'(ADDR_W'(r_row) * COLS_A + ADDR_W'(r_col));
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= LAST_COL)
        else $error("cursor column beyond last column");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= LAST_ROW)
        else $error("row rotation offset out of range");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCROLL) |-> (r_row == LAST_ROW))
        else $error("scroll while cursor not on bottom row");

    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_item.kind == KIND_CLEAR)
            |-> (r_row == '0 && r_col == '0 && r_top == '0))
        else $error("clear finished without homing cursor");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_EXEC || r_state == S_TAB ||
                      r_state == S_SCROLL || r_state == S_CLEAR))
        else $error("cell write outside a writing state");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the text console: cell store, cursor, scroll and clear.
`timescale 1ns / 1ps

module tb_top;
    import tccs_pkg::*;

    localparam int COLS      = DEF_COLUMNS;
    localparam int ROWS      = DEF_ROWS;
    localparam int TAB_STOP  = DEF_TAB_STOP;
    localparam int CYCLE_CAP = 1000000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [CUR_ROW_W-1:0] row;
        logic [CUR_COL_W-1:0] col;
        logic [CUR_POS_W-1:0] pos;
    } t_screen_reply;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [ATTR_W-1:0]     cfg_wr_data = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind        = '0;
    logic [CHAR_W-1:0]     char_code   = '0;
    logic [READ_ROW_W-1:0] read_row    = '0;
    logic [READ_COL_W-1:0] read_col    = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [CELL_W-1:0]     cell_value;
    logic [CUR_ROW_W-1:0]  cursor_row;
    logic [CUR_COL_W-1:0]  cursor_col;
    logic [CUR_POS_W-1:0]  cursor_position;

    // predicted console state
    logic [CELL_W-1:0] screen_mem [0:ROWS*COLS-1];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] cur_attr;

    t_screen_reply expected_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_len      = 0;
    int hold_done     = 0;
    int cycle_count   = 0;
    int error_count   = 0;
    int items_sent    = 0;
    int replies_seen  = 0;
    int scroll_count  = 0;
    int clear_count   = 0;

    text_console_cursor_scroll dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_wr_data     (cfg_wr_data),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (kind),
        .i_char_code       (char_code),
        .i_read_row        (read_row),
        .i_read_col        (read_col),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_cell_value      (cell_value),
        .o_cursor_row      (cursor_row),
        .o_cursor_col      (cursor_col),
        .o_cursor_position (cursor_position)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver: one long hold when requested, otherwise random stalls
    always @(posedge clk) begin
        if (hold_len != 0 && hold_done < hold_len) begin
            out_stall <= 1'b1;
            hold_done <= hold_done + 1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_replies
        t_screen_reply want;
        if (rst_n && out_valid && !out_stall) begin
            replies_seen++;
            if (expected_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual cell %h row %0d col %0d pos %0d",
                         $time, cell_value, cursor_row, cursor_col, cursor_position);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (cell_value !== want.cell_data) begin
                    $display("%0t: cell_value expected %h actual %h",
                             $time, want.cell_data, cell_value);
                    error_count++;
                end
                if (cursor_row !== want.row) begin
                    $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, cursor_row);
                    error_count++;
                end
                if (cursor_col !== want.col) begin
                    $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, cursor_col);
                    error_count++;
                end
                if (cursor_position !== want.pos) begin
                    $display("%0t: cursor_position expected %0d actual %0d",
                             $time, want.pos, cursor_position);
                    error_count++;
                end
            end
        end
    end

    task automatic blank_screen();
        for (int i = 0; i < ROWS*COLS; i++) screen_mem[i] = {cur_attr, CHAR_SPACE};
        cur_row = 0;
        cur_col = 0;
    endtask

    task automatic advance_line();
        cur_col = 0;
        cur_row++;
        if (cur_row >= ROWS) begin
            for (int i = 0; i < (ROWS-1)*COLS; i++) screen_mem[i] = screen_mem[i+COLS];
            for (int x = 0; x < COLS; x++) screen_mem[(ROWS-1)*COLS + x] = {cur_attr, CHAR_SPACE};
            cur_row = ROWS - 1;
            scroll_count++;
        end
    endtask

    // works out the reply for one accepted item and queues it
    task automatic predict_console(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                                   input logic [READ_ROW_W-1:0] rr,
                                   input logic [READ_COL_W-1:0] rc);
        t_screen_reply r;
        int            base;
        int            n;
        r = '0;
        base = cur_row * COLS;
        case (k)
            KIND_PUT: begin
                if (ch == CHAR_LF) begin
                    advance_line();
                end else if (ch == CHAR_TAB) begin
                    n = TAB_STOP - (cur_col % TAB_STOP);
                    while (n > 0 && cur_col < COLS) begin
                        screen_mem[base + cur_col] = {cur_attr, CHAR_SPACE};
                        cur_col++;
                        n--;
                    end
                    if (cur_col >= COLS) advance_line();
                end else if (ch == CHAR_CR) begin
                    cur_col = 0;
                end else if (ch == CHAR_BS) begin
                    if (cur_col > 0) begin
                        cur_col--;
                        screen_mem[base + cur_col] = {cur_attr, CHAR_SPACE};
                    end
                end else begin
                    screen_mem[base + cur_col] = {cur_attr, ch};
                    cur_col++;
                    if (cur_col >= COLS) advance_line();
                end
            end
            KIND_READ: begin
                if (int'(rr) < ROWS && int'(rc) < COLS)
                    r.cell_data = screen_mem[int'(rr)*COLS + int'(rc)];
            end
            KIND_CLEAR: begin
                blank_screen();
                clear_count++;
            end
            default: ;
        endcase
        r.row = CUR_ROW_W'(cur_row);
        r.col = CUR_COL_W'(cur_col);
        r.pos = CUR_POS_W'(cur_row * COLS + cur_col);
        expected_replies.push_back(r);
    endtask

    // offers one item, returns at the edge that accepts it without touching in_valid
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] ch,
                             input logic [READ_ROW_W-1:0] rr, input logic [READ_COL_W-1:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        do @(posedge clk); while (in_stall);
        predict_console(k, ch, rr, rc);
        items_sent++;
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(KIND_PUT, ch, READ_ROW_W'($urandom), READ_COL_W'($urandom));
    endtask

    task automatic read_cell(input int r, input int c);
        send_item(KIND_READ, CHAR_W'($urandom), READ_ROW_W'(r), READ_COL_W'(c));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic set_attribute(input logic [ATTR_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_attr = value;
    endtask

    task automatic test_reset_state();
        read_cell(0, 0);
        read_cell(ROWS-1, COLS-1);
        read_cell(12, 40);
        send_item(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_control_codes();
        set_attribute(8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h80);
        put_char(8'h41);
        put_char(CHAR_BS);
        read_cell(0, 3);
        read_cell(0, 0);
        set_attribute(8'h00);
        put_char(CHAR_TAB);
        put_char(CHAR_TAB);
        put_char(CHAR_CR);
        put_char(CHAR_BS);          // at column 0: no effect
        put_char(CHAR_LF);
        read_cell(0, 1);
        send_item(KIND_UNUSED, 8'h00, 5'h00, 7'h00);
        read_cell(31, 127);
        read_cell(ROWS, 0);
        read_cell(0, COLS);
        send_item(KIND_CLEAR, 8'h55, 5'h0A, 7'h2A);
        read_cell(5, 5);
    endtask

    // tab that runs into the line end, then line feeds and a full line that force scrolls
    task automatic test_line_ends();
        set_attribute(8'h5A);
        repeat (COLS/TAB_STOP - 1) put_char(CHAR_TAB);
        put_char(8'h78);
        put_char(CHAR_TAB);
        read_cell(0, COLS-1);
        repeat (ROWS) put_char(CHAR_LF);
        read_cell(ROWS-2, 0);
        for (int i = 0; i < COLS; i++) put_char(CHAR_W'(8'h30 + i));
        read_cell(ROWS-2, COLS-1);
        read_cell(ROWS-1, 0);
        put_char(CHAR_BS);
    endtask

    // long receiver hold while the sender keeps offering items, then a full drain
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_len = 400;
        repeat (16) put_char(CHAR_W'($urandom_range(32, 126)));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
        int               pick;
        logic [CHAR_W-1:0] ch;
        int               rr;
        int               rc;
        set_attribute(ATTR_W'($urandom));
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) begin
            pick = $urandom_range(999);
            ch   = CHAR_W'($urandom);
            if (pick < 540) begin
                put_char(ch);
            end else if (pick < 640) begin
                put_char(CHAR_LF);
            end else if (pick < 690) begin
                put_char(CHAR_CR);
            end else if (pick < 750) begin
                put_char(CHAR_BS);
            end else if (pick < 820) begin
                put_char(CHAR_TAB);
            end else if (pick < 970) begin
                // half near the cursor, a quarter anywhere on screen, a quarter anywhere in the field range
                case ($urandom_range(3))
                    0: begin rr = $urandom_range(31); rc = $urandom_range(127); end
                    1: begin rr = $urandom_range(ROWS-1); rc = $urandom_range(COLS-1); end
                    default: begin
                        rr = cur_row;
                        rc = (cur_col > 0) ? cur_col - 1 : $urandom_range(COLS-1);
                    end
                endcase
                read_cell(rr, rc);
            end else if (pick < 985) begin
                send_item(KIND_CLEAR, ch, READ_ROW_W'($urandom), READ_COL_W'($urandom));
            end else begin
                send_item(KIND_UNUSED, ch, READ_ROW_W'($urandom), READ_COL_W'($urandom));
            end
        end
    endtask

    initial begin
        cur_attr = RESET_ATTR;
        blank_screen();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 22;
        recv_idle_pct = 52;
        test_reset_state();
        test_control_codes();
        test_line_ends();
        test_backpressure();
        test_random_traffic(22, 52, 220);
        test_random_traffic(52, 22, 220);
        test_random_traffic(0, 0, 220);
        wait_drained();
        repeat (100) @(posedge clk);
        $display("Covered %0d items and %0d results: puts, control codes, reads, clears, unused kind",
                 items_sent, replies_seen);
        $display("with %0d scrolls, %0d clears, attribute extremes and a long output hold",
                 scroll_count, clear_count);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
